>>> src/hrp_pkg.sv
package hrp_pkg;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;

   localparam logic [23:0] METHOD_GET    = "GET";
   localparam logic [31:0] METHOD_POST   = "POST";
   localparam logic [23:0] METHOD_PUT    = "PUT";
   localparam logic [47:0] METHOD_DELETE = "DELETE";
   localparam logic [31:0] METHOD_HEAD   = "HEAD";
   localparam logic [39:0] METHOD_PATCH  = "PATCH";
   localparam logic [31:0] RESPONSE_HTTP = "HTTP";

   typedef enum logic [2:0] {
      STATUS_NOT_TCP   = 3'd0,
      STATUS_FILTERED  = 3'd1,
      STATUS_NOT_HTTP  = 3'd2,
      STATUS_STORED    = 3'd3,
      STATUS_FULL      = 3'd4,
      STATUS_PAIRED    = 3'd5,
      STATUS_UNMATCHED = 3'd6
   } status_type;

   // Packed with the last declared field, ether_type, in the lowest bits.
   typedef struct packed {
      logic [63:0] arrival_time;
      logic [47:0] payload_head;
      logic [31:0] ack_num;
      logic [31:0] seq_num;
      logic [15:0] dst_port;
      logic [15:0] src_port;
      logic [31:0] dst_ip;
      logic [31:0] src_ip;
      logic [7:0]  ip_protocol;
      logic [15:0] ether_type;
   } item_type;

   typedef struct packed {
      logic [63:0] latency;
      logic [31:0] req_ack;
      logic [31:0] req_seq;
      logic [15:0] req_dst_port;
      logic [15:0] req_src_port;
      logic [31:0] req_dst_ip;
      logic [31:0] req_src_ip;
   } result_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] seq;
      logic [63:0] time_stamp;
   } entry_type;

   localparam int ITEM_BITS   = $bits(item_type);
   localparam int RESULT_BITS = $bits(result_type);
   localparam int STATUS_BITS = $bits(status_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load_item;
      logic scan_start;
      logic scan_issue;
      logic clear_step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic needs_scan;
      logic idx_last;
      logic out_free;
   } dp_status_type;

endpackage

>>> src/hrp_ctrl.sv
module hrp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hrp_pkg::dp_status_type dp_status,
   output hrp_pkg::ctrl_cmd_type  cmd
);
   import hrp_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (dp_status.idx_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (in_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = dp_status.needs_scan ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            if (dp_status.idx_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (dp_status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            in_ready      = 1'b1;
            cmd.load_item = in_valid;
         end
         ST_DECIDE: begin
            cmd.scan_start = dp_status.needs_scan;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            cmd.finish = dp_status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> src/hrp_datapath.sv
module hrp_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [31:0]                         csr_wr_data,
   input  logic [hrp_pkg::ITEM_BITS-1:0]       req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hrp_pkg::RESULT_BITS-1:0]     rsp_tdata,
   output logic [hrp_pkg::STATUS_BITS-1:0]     rsp_tuser,
   input  hrp_pkg::ctrl_cmd_type               cmd,
   output hrp_pkg::dp_status_type              dp_status
);
   import hrp_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

   entry_type table_mem [TABLE_DEPTH];

   logic [31:0]      target_ip_ff, target_ip_in;
   item_type         item_ff, item_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   entry_type        rd_entry_ff;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   entry_type        hit_ff, hit_in;
   logic             out_valid_ff, out_valid_in;
   status_type       out_status_ff, out_status_in;
   result_type       out_data_ff, out_data_in;

   logic        is_tcp;
   logic        addr_ok;
   logic        is_req;
   logic        is_rsp;
   logic [31:0] scan_key;
   logic        key_hit;
   logic        out_free;
   status_type  fin_status;
   logic        fin_write;
   logic [IDX_W-1:0] fin_slot;
   entry_type   fin_entry;
   logic        wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type   wr_entry;
   result_type  fin_data;

   assign is_tcp  = (item_ff.ether_type == ETHERTYPE_IPV4) && (item_ff.ip_protocol == PROTO_TCP);
   assign addr_ok = (item_ff.src_ip == target_ip_ff) || (item_ff.dst_ip == target_ip_ff);
   assign is_req  = (item_ff.payload_head[47:24] == METHOD_GET)
                 || (item_ff.payload_head[47:16] == METHOD_POST)
                 || (item_ff.payload_head[47:24] == METHOD_PUT)
                 || (item_ff.payload_head == METHOD_DELETE)
                 || (item_ff.payload_head[47:16] == METHOD_HEAD)
                 || (item_ff.payload_head[47:8] == METHOD_PATCH);
   assign is_rsp  = (item_ff.payload_head[47:16] == RESPONSE_HTTP);
   assign scan_key = is_req ? item_ff.ack_num : item_ff.seq_num;
   assign key_hit  = rd_entry_ff.valid && (rd_entry_ff.key == scan_key);
   assign out_free = !out_valid_ff || rsp_tready;

   assign dp_status.needs_scan = is_tcp && addr_ok && (is_req || is_rsp);
   assign dp_status.idx_last   = (idx_ff == IDX_LAST);
   assign dp_status.out_free   = out_free;

   always_comb begin
      fin_status = STATUS_NOT_HTTP;
      fin_write  = 1'b0;
      fin_slot   = found_idx_ff;
      fin_entry  = '0;
      fin_data   = '0;
      priority if (!is_tcp) begin
         fin_status = STATUS_NOT_TCP;
      end else if (!addr_ok) begin
         fin_status = STATUS_FILTERED;
      end else if (is_req) begin
         fin_entry.valid      = 1'b1;
         fin_entry.key        = item_ff.ack_num;
         fin_entry.src_ip     = item_ff.src_ip;
         fin_entry.dst_ip     = item_ff.dst_ip;
         fin_entry.src_port   = item_ff.src_port;
         fin_entry.dst_port   = item_ff.dst_port;
         fin_entry.seq        = item_ff.seq_num;
         fin_entry.time_stamp = item_ff.arrival_time;
         priority if (found_ff) begin
            fin_status = STATUS_STORED;
            fin_write  = 1'b1;
         end else if (free_found_ff) begin
            fin_status = STATUS_STORED;
            fin_write  = 1'b1;
            fin_slot   = free_idx_ff;
         end else begin
            fin_status = STATUS_FULL;
         end
      end else if (is_rsp) begin
         if (found_ff) begin
            fin_status            = STATUS_PAIRED;
            fin_write             = 1'b1;
            fin_data.req_src_ip   = hit_ff.src_ip;
            fin_data.req_dst_ip   = hit_ff.dst_ip;
            fin_data.req_src_port = hit_ff.src_port;
            fin_data.req_dst_port = hit_ff.dst_port;
            fin_data.req_seq      = hit_ff.seq;
            fin_data.req_ack      = hit_ff.key;
            fin_data.latency      = item_ff.arrival_time - hit_ff.time_stamp;
         end else begin
            fin_status = STATUS_UNMATCHED;
         end
      end else begin
         fin_status = STATUS_NOT_HTTP;
      end
   end

   assign wr_en    = cmd.clear_step || (cmd.finish && fin_write);
   assign wr_addr  = cmd.clear_step ? idx_ff : fin_slot;
   assign wr_entry = cmd.clear_step ? entry_type'('0) : fin_entry;

   always_comb begin
      target_ip_in  = csr_wr_en ? csr_wr_data : target_ip_ff;
      item_in       = cmd.load_item ? item_type'(req_tdata) : item_ff;
      idx_in        = idx_ff;
      rd_pend_in    = cmd.scan_issue;
      rd_idx_in     = idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_in        = hit_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_data_in   = out_data_ff;

      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.scan_issue || cmd.clear_step) begin
         idx_in = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
      end

      if (cmd.scan_start) begin
         found_in      = 1'b0;
         free_found_in = 1'b0;
      end else if (rd_pend_ff) begin
         if (key_hit && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = rd_idx_ff;
            hit_in       = rd_entry_ff;
         end
         if (!rd_entry_ff.valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end

      if (cmd.finish) begin
         out_valid_in  = 1'b1;
         out_status_in = fin_status;
         out_data_in   = fin_data;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_entry;
      end
      if (cmd.scan_issue) begin
         rd_entry_ff <= table_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ip_ff  <= '0;
         idx_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         target_ip_ff  <= target_ip_in;
         idx_ff        <= idx_in;
         rd_pend_ff    <= rd_pend_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      rd_idx_ff     <= rd_idx_in;
      found_idx_ff  <= found_idx_in;
      free_idx_ff   <= free_idx_in;
      hit_ff        <= hit_in;
      out_status_ff <= out_status_in;
      out_data_ff   <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

>>> src/http_request_response_pairer.sv
// A TCP request or response word to or from the target address is matched by a key search
// that reads one table entry per cycle; other words skip the search. A new word is accepted
// only in the idle state, after the result of the last word has entered the output register.
// Reset is synchronous and active high; after it a clearing pass empties every table entry,
// during which no word is accepted. The target address resets to 0.
module http_request_response_pairer #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [31:0]                         csr_wr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // ether_type, ip_protocol, src_ip, dst_ip, src_port, dst_port, seq_num, ack_num,
   // payload_head, arrival_time
   input  logic [hrp_pkg::ITEM_BITS-1:0]       req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // req_src_ip, req_dst_ip, req_src_port, req_dst_port, req_seq, req_ack, latency
   output logic [hrp_pkg::RESULT_BITS-1:0]     rsp_tdata,
   // status
   output logic [hrp_pkg::STATUS_BITS-1:0]     rsp_tuser
);
   import hrp_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   hrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   hrp_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .cmd         (cmd),
      .dp_status   (dp_status)
   );

endmodule
